### rtl/core/i2cms_pkg.sv
// ---------------------------------------------------------------------------
// i2cms_pkg
// Types, codes and defaults shared by the I2C master event sequencer.
// ---------------------------------------------------------------------------
package i2cms_pkg;

   localparam int unsigned BUF_DEPTH_DEFAULT = 256;
   // load_index never reaches past 256 bytes; the transfer length can only when BUF_DEPTH exceeds 256
   localparam int unsigned STORE_DEPTH_MAX   = 256;

   // request function codes
   localparam logic [2:0] FUNC_START_TX = 3'd0;
   localparam logic [2:0] FUNC_START_RX = 3'd1;
   localparam logic [2:0] FUNC_STATUS   = 3'd2;
   localparam logic [2:0] FUNC_ERROR    = 3'd3;
   localparam logic [2:0] FUNC_LOAD     = 3'd4;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_ERROR = 2'd1;
   localparam logic [1:0] STAT_BUSY  = 2'd2;
   localparam logic [1:0] STAT_NONE  = 2'd3;

   localparam logic [1:0] ACK_LEAVE   = 2'd0;
   localparam logic [1:0] ACK_ENABLE  = 2'd1;
   localparam logic [1:0] ACK_DISABLE = 2'd2;

   localparam logic [1:0] IRQ_LEAVE   = 2'd0;
   localparam logic [1:0] IRQ_ENABLE  = 2'd1;
   localparam logic [1:0] IRQ_DISABLE = 2'd2;

   localparam logic [1:0] CMPL_NONE  = 2'd0;
   localparam logic [1:0] CMPL_TX    = 2'd1;
   localparam logic [1:0] CMPL_RX    = 2'd2;
   localparam logic [1:0] CMPL_ABORT = 2'd3;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_TX   = 2'd1,
      MODE_RX   = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      EV_NONE,
      EV_START,
      EV_START_ERR,
      EV_START_BUSY,
      EV_SB,
      EV_TX_BYTE,
      EV_TX_DONE,
      EV_RX_BYTE,
      EV_NO_MATCH,
      EV_ABORT,
      EV_LOAD
   } event_type;

   typedef struct packed {
      logic [2:0] func;
      logic [6:0] target_addr;
      logic [8:0] length;
      logic       flag_sb;
      logic       flag_addr;
      logic       flag_txe;
      logic       flag_btf;
      logic       flag_rxne;
      logic [7:0] rx_byte;
      logic [7:0] load_index;
      logic [7:0] load_value;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic       dr_write_valid;
      logic [7:0] dr_value;
      logic       gen_start;
      logic       gen_stop;
      logic [1:0] ack_control;
      logic [1:0] irq_control;
      logic       store_valid;
      logic [7:0] store_index;
      logic [7:0] store_value;
      logic [1:0] completion;
      logic [1:0] busy_state;
   } rsp_payload_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] addr_byte;
      logic [8:0] xfer_len;
      logic [8:0] xfer_pos;
   } seq_state_type;

   // step decision handed to the datapath around the store
   typedef struct packed {
      logic store_wr;   // load item lands in the tx store
      logic tx_read;    // dr_value comes from the tx store read
   } step_ctrl_type;

endpackage

### rtl/core/i2cms_if.sv
// ---------------------------------------------------------------------------
// i2cms_if
// Valid/ready channels for sequencer requests and responses.
// ---------------------------------------------------------------------------
interface i2cms_req_if;
   logic                        valid;
   logic                        ready;
   i2cms_pkg::req_payload_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface i2cms_rsp_if;
   logic                        valid;
   logic                        ready;
   i2cms_pkg::rsp_payload_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/i2cms_step.sv
// ---------------------------------------------------------------------------
// i2cms_step
// Decodes one transaction against the sequencer state and produces the next
// state, the response fields and the tx store controls.
// ---------------------------------------------------------------------------
module i2cms_step #(
   parameter int unsigned BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEFAULT
) (
   input  i2cms_pkg::req_payload_type item,
   input  i2cms_pkg::seq_state_type   state_cur,
   output i2cms_pkg::seq_state_type   state_nxt,
   output i2cms_pkg::rsp_payload_type result,
   output i2cms_pkg::step_ctrl_type   ctrl
);

   i2cms_pkg::event_type ev;
   logic                 len_bad;
   logic                 load_ok;
   logic                 more;
   logic [8:0]           pos_inc;
   logic                 rx_last;

   assign len_bad = (item.length == 9'd0) || (32'(item.length) > BUF_DEPTH);
   assign load_ok = 32'(item.load_index) < BUF_DEPTH;
   assign more    = state_cur.xfer_pos < state_cur.xfer_len;
   assign pos_inc = state_cur.xfer_pos + 9'd1;
   assign rx_last = pos_inc == state_cur.xfer_len;

   // event decode, status flags in priority order
   always_comb begin
      ev = i2cms_pkg::EV_NONE;
      unique case (item.func) inside
         i2cms_pkg::FUNC_START_TX, i2cms_pkg::FUNC_START_RX: begin
            if (len_bad)
               ev = i2cms_pkg::EV_START_ERR;
            else if (state_cur.mode != i2cms_pkg::MODE_IDLE)
               ev = i2cms_pkg::EV_START_BUSY;
            else
               ev = i2cms_pkg::EV_START;
         end
         i2cms_pkg::FUNC_STATUS: begin
            if (item.flag_sb)
               ev = i2cms_pkg::EV_SB;
            else if (item.flag_addr)
               ev = i2cms_pkg::EV_NONE;
            else if (item.flag_txe && state_cur.mode == i2cms_pkg::MODE_TX) begin
               if (more)
                  ev = i2cms_pkg::EV_TX_BYTE;
               else if (item.flag_btf)
                  ev = i2cms_pkg::EV_TX_DONE;
               else
                  ev = i2cms_pkg::EV_NONE;
            end else if (item.flag_btf && state_cur.mode == i2cms_pkg::MODE_TX && !more)
               ev = i2cms_pkg::EV_TX_DONE;
            else if (item.flag_rxne && state_cur.mode == i2cms_pkg::MODE_RX)
               ev = more ? i2cms_pkg::EV_RX_BYTE : i2cms_pkg::EV_NONE;
            else
               ev = i2cms_pkg::EV_NO_MATCH;
         end
         i2cms_pkg::FUNC_ERROR: ev = i2cms_pkg::EV_ABORT;
         i2cms_pkg::FUNC_LOAD:  ev = i2cms_pkg::EV_LOAD;
         default:               ev = i2cms_pkg::EV_NONE;
      endcase
   end

   // next state
   always_comb begin
      state_nxt = state_cur;
      unique case (ev)
         i2cms_pkg::EV_START: begin
            state_nxt.mode      = (item.func == i2cms_pkg::FUNC_START_RX) ?
                                  i2cms_pkg::MODE_RX : i2cms_pkg::MODE_TX;
            state_nxt.addr_byte = {item.target_addr, item.func[0]};
            state_nxt.xfer_len  = item.length;
            state_nxt.xfer_pos  = 9'd0;
         end
         i2cms_pkg::EV_TX_BYTE: state_nxt.xfer_pos = pos_inc;
         i2cms_pkg::EV_TX_DONE: state_nxt.mode = i2cms_pkg::MODE_IDLE;
         i2cms_pkg::EV_RX_BYTE: begin
            state_nxt.xfer_pos = pos_inc;
            if (rx_last)
               state_nxt.mode = i2cms_pkg::MODE_IDLE;
         end
         i2cms_pkg::EV_ABORT: state_nxt.mode = i2cms_pkg::MODE_IDLE;
         default: ;
      endcase
   end

   // response fields and store controls
   always_comb begin
      result            = '0;
      result.status     = i2cms_pkg::STAT_NONE;
      result.busy_state = state_nxt.mode;
      ctrl              = '0;
      unique case (ev)
         i2cms_pkg::EV_START: begin
            result.status      = i2cms_pkg::STAT_OK;
            result.gen_start   = 1'b1;
            result.irq_control = i2cms_pkg::IRQ_ENABLE;
            if (item.func == i2cms_pkg::FUNC_START_RX)
               result.ack_control = i2cms_pkg::ACK_ENABLE;
         end
         i2cms_pkg::EV_START_ERR:  result.status = i2cms_pkg::STAT_ERROR;
         i2cms_pkg::EV_START_BUSY: result.status = i2cms_pkg::STAT_BUSY;
         i2cms_pkg::EV_SB: begin
            result.dr_write_valid = 1'b1;
            result.dr_value       = state_cur.addr_byte;
         end
         i2cms_pkg::EV_TX_BYTE: begin
            result.dr_write_valid = 1'b1;
            ctrl.tx_read          = 1'b1;
         end
         i2cms_pkg::EV_TX_DONE: begin
            result.gen_stop    = 1'b1;
            result.irq_control = i2cms_pkg::IRQ_DISABLE;
            result.completion  = i2cms_pkg::CMPL_TX;
         end
         i2cms_pkg::EV_RX_BYTE: begin
            result.store_valid = 1'b1;
            result.store_index = state_cur.xfer_pos[7:0];
            result.store_value = item.rx_byte;
            if (rx_last) begin
               result.ack_control = i2cms_pkg::ACK_DISABLE;
               result.gen_stop    = 1'b1;
               result.irq_control = i2cms_pkg::IRQ_DISABLE;
               result.completion  = i2cms_pkg::CMPL_RX;
            end
         end
         i2cms_pkg::EV_NO_MATCH: result.irq_control = i2cms_pkg::IRQ_DISABLE;
         i2cms_pkg::EV_ABORT: begin
            result.irq_control = i2cms_pkg::IRQ_DISABLE;
            result.completion  = i2cms_pkg::CMPL_ABORT;
         end
         i2cms_pkg::EV_LOAD: ctrl.store_wr = load_ok;
         default: ;
      endcase
   end

endmodule

### rtl/core/i2c_master_event_sequencer_top.sv
// ---------------------------------------------------------------------------
// i2c_master_event_sequencer_top
// Interrupt-driven I2C master transfer sequencer for one port.
// ---------------------------------------------------------------------------
// Takes one transaction per cycle sustained while the response side is not
// stalled, and returns one response per transaction through the s1 stage
// registers and then the response register. The transmit byte store is a
// synchronous memory of min(BUF_DEPTH, 256) bytes with one write and one
// read port; its read for the next transmit byte is issued in the
// acceptance cycle and lands in rd_data_ff beside the s1 stage. Store
// entries are not cleared at reset and must be loaded before they are
// transmitted. Control state sits in flops and is updated at acceptance, so
// back-to-back transactions see each other's effects without stalls.
module i2c_master_event_sequencer_top #(
   parameter int unsigned BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   i2cms_req_if.sink    req_chan,
   i2cms_rsp_if.source  rsp_chan
);

   localparam int unsigned STORE_DEPTH = (BUF_DEPTH < i2cms_pkg::STORE_DEPTH_MAX) ?
                                         BUF_DEPTH : i2cms_pkg::STORE_DEPTH_MAX;
   localparam int unsigned STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   i2cms_pkg::seq_state_type   state_ff, state_in, state_nxt;
   i2cms_pkg::rsp_payload_type step_rsp;
   i2cms_pkg::step_ctrl_type   step_ctrl;

   logic [7:0]                 tx_store_mem [STORE_DEPTH];
   logic [7:0]                 rd_data_ff;

   logic                       s1_valid_ff, s1_valid_in;
   i2cms_pkg::rsp_payload_type s1_rsp_ff;
   logic                       s1_tx_read_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   i2cms_pkg::rsp_payload_type rsp_data_ff;
   i2cms_pkg::rsp_payload_type s1_merged;

   logic                       out_take;
   logic                       s1_adv;
   logic                       accept;

   i2cms_step #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_step (
      .item      (req_chan.data),
      .state_cur (state_ff),
      .state_nxt (state_nxt),
      .result    (step_rsp),
      .ctrl      (step_ctrl)
   );

   assign out_take       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && out_take;
   assign req_chan.ready = !reset && (!s1_valid_ff || out_take);
   assign accept         = req_chan.valid && req_chan.ready;

   assign state_in     = accept ? state_nxt : state_ff;
   assign s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '{mode: i2cms_pkg::MODE_IDLE, default: '0};
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // tx store: a load and a transmit read never share one transaction
   always_ff @(posedge clock) begin
      if (accept && step_ctrl.store_wr)
         tx_store_mem[req_chan.data.load_index[STORE_AW-1:0]] <= req_chan.data.load_value;
      if (accept)
         rd_data_ff <= tx_store_mem[state_ff.xfer_pos[STORE_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rsp_ff     <= step_rsp;
         s1_tx_read_ff <= step_ctrl.tx_read;
      end
      if (s1_adv)
         rsp_data_ff <= s1_merged;
   end

   always_comb begin
      s1_merged = s1_rsp_ff;
      if (s1_tx_read_ff)
         s1_merged.dr_value = rd_data_ff;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule
